// ===== design/rmva_pkg.sv =====
package rmva_pkg;

    localparam int COUNT_BITS = 32;
    localparam int VAL_W      = 32;
    localparam int SQ_W       = 63;
    localparam int SUM_W      = 64;
    localparam int W_W        = 16;
    localparam int MAG_W      = VAL_W + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DIV_STEPS  = 64;
    localparam int DIVC_W     = $clog2(DIV_STEPS);

    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_MERGE = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MS_AD_B  = 2'd0,
        MS_AD_AE = 2'd1,
        MS_XLO   = 2'd2,
        MS_XHI   = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     lo_en;
        logic     div_load;
        logic     div_step;
        logic     upd;
        logic     satx;
        logic     comb;
        logic     acc;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic arith;
    } status_t;

endpackage

// ===== design/rmva_ctrl.sv =====
module rmva_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  rmva_pkg::status_t   status,
    output rmva_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_MUL1, ST_DIVLD, ST_DIV, ST_UPD, ST_MUL2,
        ST_SATX, ST_MUL3, ST_MUL4, ST_COMB, ST_ACC, ST_FIN
    } state_t;

    state_t state_reg;
    logic [rmva_pkg::DIVC_W-1:0] divc_reg;
    logic m_tvalid_reg;
    logic slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        cmd = '0;
        cmd.mul_sel = rmva_pkg::MS_AD_B;
        case (state_reg)
            ST_IDLE:  cmd.load = s_tvalid;
            ST_MUL1:  begin cmd.mul_en = 1'b1; cmd.mul_sel = rmva_pkg::MS_AD_B; end
            ST_DIVLD: cmd.div_load = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_UPD:   cmd.upd = 1'b1;
            ST_MUL2:  begin cmd.mul_en = 1'b1; cmd.mul_sel = rmva_pkg::MS_AD_AE; end
            ST_SATX:  cmd.satx = 1'b1;
            ST_MUL3:  begin cmd.lo_en = 1'b1; cmd.mul_sel = rmva_pkg::MS_XLO; end
            ST_MUL4:  begin cmd.mul_en = 1'b1; cmd.mul_sel = rmva_pkg::MS_XHI; end
            ST_COMB:  cmd.comb = 1'b1;
            ST_ACC:   cmd.acc = 1'b1;
            ST_FIN:   cmd.out_load = slot_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            divc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && slot_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:  if (s_tvalid) state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= status.arith ? ST_MUL1 : ST_FIN;
                ST_MUL1:  state_reg <= ST_DIVLD;
                ST_DIVLD: begin
                    divc_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    divc_reg <= divc_reg + 1'b1;
                    if (divc_reg == rmva_pkg::DIVC_W'(rmva_pkg::DIV_STEPS - 1))
                        state_reg <= ST_UPD;
                end
                ST_UPD:   state_reg <= ST_MUL2;
                ST_MUL2:  state_reg <= ST_SATX;
                ST_SATX:  state_reg <= ST_MUL3;
                ST_MUL3:  state_reg <= ST_MUL4;
                ST_MUL4:  state_reg <= ST_COMB;
                ST_COMB:  state_reg <= ST_ACC;
                ST_ACC:   state_reg <= ST_FIN;
                ST_FIN: begin
                    if (slot_free) state_reg <= ST_IDLE;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/rmva_datapath.sv =====
module rmva_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmva_pkg::cmd_t                       cmd,
    output rmva_pkg::status_t                    status,
    input  logic [1:0]                           func,
    input  logic signed [rmva_pkg::VAL_W-1:0]    sample_value,
    input  logic [rmva_pkg::W_W-1:0]             weight,
    input  logic [rmva_pkg::COUNT_BITS-1:0]      other_count,
    input  logic signed [rmva_pkg::VAL_W-1:0]    other_mean,
    input  logic [rmva_pkg::SQ_W-1:0]            other_sq_dev,
    input  logic signed [rmva_pkg::SUM_W-1:0]    other_total,
    input  logic signed [rmva_pkg::VAL_W-1:0]    other_min,
    input  logic signed [rmva_pkg::VAL_W-1:0]    other_max,
    output logic [rmva_pkg::COUNT_BITS-1:0]      total_count,
    output logic signed [rmva_pkg::VAL_W-1:0]    running_mean,
    output logic [rmva_pkg::SQ_W-1:0]            sq_dev_sum,
    output logic signed [rmva_pkg::SUM_W-1:0]    value_sum,
    output logic signed [rmva_pkg::VAL_W-1:0]    min_value,
    output logic signed [rmva_pkg::VAL_W-1:0]    max_value
);

    localparam int CB = rmva_pkg::COUNT_BITS;
    localparam int VW = rmva_pkg::VAL_W;
    localparam int MW = rmva_pkg::MAG_W;
    localparam int SW = rmva_pkg::SQ_W;
    localparam int UW = rmva_pkg::SUM_W;
    localparam int PW = rmva_pkg::PROD_W;

    // statistics
    logic [CB-1:0]        count_reg;
    logic signed [VW-1:0] mean_reg;
    logic [SW-1:0]        sq_reg;
    logic [UW-1:0]        sum_reg;
    logic signed [VW-1:0] min_reg, max_reg;

    // per-word working registers
    logic [1:0]           op_reg;
    logic                 arith_reg;
    logic signed [VW-1:0] val_reg;
    logic                 neg_reg;
    logic [MW-1:0]        ad_reg;
    logic [CB-1:0]        m1b_reg;
    logic [CB-1:0]        w2_reg;
    logic [MW-1:0]        ae_reg;
    logic [PW-1:0]        prod_reg;
    logic [63:0]          lo_reg;
    logic [SW-1:0]        x_reg;
    logic [SW-1:0]        term_reg;
    logic [63:0]          num_reg;
    logic [CB-1:0]        rem_reg;

    assign status.arith = arith_reg;

    // count, delta, sum and squared-deviation update terms
    logic [CB:0]    cnt_sum;
    logic [CB-1:0]  cnt_new;
    logic [CB-1:0]  addend;
    logic signed [VW-1:0] target;
    logic signed [MW-1:0] delta;
    logic [MW-1:0]  delta_mag;
    logic [UW-1:0]  sum_add, sum_res, sum_sat;
    logic [SW:0]    sq_osq;

    always_comb begin
        addend    = (func == rmva_pkg::FN_ADD) ? CB'(weight) : other_count;
        cnt_sum   = {1'b0, count_reg} + {1'b0, addend};
        cnt_new   = cnt_sum[CB] ? rmva_pkg::COUNT_MAX : cnt_sum[CB-1:0];
        target    = (func == rmva_pkg::FN_ADD) ? sample_value : other_mean;
        delta     = MW'(target) - MW'(mean_reg);
        delta_mag = delta[MW-1] ? MW'(-delta) : MW'(delta);
        sum_add   = (func == rmva_pkg::FN_ADD) ? UW'(sample_value) : other_total;
        sum_res   = sum_reg + sum_add;
        if (sum_reg[UW-1] == sum_add[UW-1] && sum_res[UW-1] != sum_reg[UW-1])
            sum_sat = sum_reg[UW-1] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
        else
            sum_sat = sum_res;
        sq_osq = {1'b0, sq_reg} + {1'b0, other_sq_dev};
    end

    // shared multiplier
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;

    always_comb begin
        case (cmd.mul_sel)
            rmva_pkg::MS_AD_B:  begin mul_a = ad_reg; mul_b = MW'(m1b_reg); end
            rmva_pkg::MS_AD_AE: begin mul_a = ad_reg; mul_b = ae_reg; end
            rmva_pkg::MS_XLO:   begin mul_a = MW'(x_reg[31:0]); mul_b = MW'(w2_reg); end
            rmva_pkg::MS_XHI:   begin mul_a = MW'(x_reg[SW-1:32]); mul_b = MW'(w2_reg); end
            default:            begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // restoring divider, one quotient bit per cycle; quotient shifts into num_reg
    logic [CB:0]   rem_sh;
    logic          qbit;
    logic [CB:0]   rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[63]};
        qbit    = (rem_sh >= {1'b0, count_reg});
        rem_sub = rem_sh - {1'b0, count_reg};
    end

    // mean step and second factor
    logic [MW-1:0]        step;
    logic signed [MW:0]   nm_wide;
    logic signed [VW-1:0] nm;
    logic signed [MW-1:0] err;
    logic [MW-1:0]        err_mag;

    always_comb begin
        step    = num_reg[MW-1:0];
        nm_wide = neg_reg ? ((MW+1)'(mean_reg) - $signed({1'b0, step}))
                          : ((MW+1)'(mean_reg) + $signed({1'b0, step}));
        nm      = nm_wide[VW-1:0];
        err     = MW'(val_reg) - MW'(nm);
        err_mag = err[MW-1] ? MW'(-err) : MW'(err);
    end

    logic [95:0] full;
    logic [SW:0] sq_term;

    always_comb begin
        full    = {prod_reg[63:0], 32'b0} + {32'b0, lo_reg};
        sq_term = {1'b0, sq_reg} + {1'b0, term_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            mean_reg  <= '0;
            sq_reg    <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            arith_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                op_reg  <= func;
                val_reg <= sample_value;
                neg_reg <= delta[MW-1];
                ad_reg  <= delta_mag;
                m1b_reg <= addend;
                w2_reg  <= (func == rmva_pkg::FN_ADD) ? CB'(weight) : count_reg;
                arith_reg <= 1'b0;
                case (func)
                    rmva_pkg::FN_ADD: begin
                        count_reg <= cnt_new;
                        sum_reg   <= sum_sat;
                        if (sample_value < min_reg) min_reg <= sample_value;
                        if (sample_value > max_reg) max_reg <= sample_value;
                        arith_reg <= (cnt_new != '0);
                    end
                    rmva_pkg::FN_MERGE: begin
                        count_reg <= cnt_new;
                        sum_reg   <= sum_sat;
                        min_reg   <= other_min;
                        max_reg   <= other_max;
                        sq_reg    <= (sq_osq > {1'b0, rmva_pkg::SQ_MAX}) ? rmva_pkg::SQ_MAX
                                                                        : sq_osq[SW-1:0];
                        if (cnt_new == '0) mean_reg <= '0;
                        arith_reg <= (cnt_new != '0);
                    end
                    rmva_pkg::FN_CLEAR: begin
                        count_reg <= '0;
                        mean_reg  <= '0;
                        sq_reg    <= '0;
                        sum_reg   <= '0;
                        min_reg   <= '0;
                        max_reg   <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.upd) mean_reg <= nm;
            if (cmd.acc)
                sq_reg <= (sq_term > {1'b0, rmva_pkg::SQ_MAX}) ? rmva_pkg::SQ_MAX
                                                              : sq_term[SW-1:0];
        end
    end

    // payload-only registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) prod_reg <= mul_p;
        if (cmd.lo_en)  lo_reg   <= mul_p[63:0];
        if (cmd.div_load) begin
            num_reg <= prod_reg[63:0];
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            num_reg <= {num_reg[62:0], qbit};
            rem_reg <= qbit ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
        end
        if (cmd.upd)
            ae_reg <= (op_reg == rmva_pkg::FN_ADD) ? err_mag : step;
        if (cmd.satx)
            x_reg <= (prod_reg > PW'(rmva_pkg::SQ_MAX)) ? rmva_pkg::SQ_MAX : prod_reg[SW-1:0];
        if (cmd.comb)
            term_reg <= (full > 96'(rmva_pkg::SQ_MAX)) ? rmva_pkg::SQ_MAX : full[SW-1:0];
        if (cmd.out_load) begin
            total_count  <= count_reg;
            running_mean <= mean_reg;
            sq_dev_sum   <= sq_reg;
            value_sum    <= sum_reg;
            min_value    <= min_reg;
            max_value    <= max_reg;
        end
    end

endmodule

// ===== design/running_mean_variance_accumulator.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser = func, s_tdata = operands
// m_        out  m_tvalid/m_tready  m_tdata = all statistics
//
// Add and merge run the 64-step restoring divider and make four passes
// through one shared 33x33 multiplier before the result is loaded.
// Clear, an add or merge whose count ends at zero, and the unused code skip both.
// Synchronous active-low reset zeroes all statistics; no clearing pass.
// A new word is taken while the previous result waits; a stalled result only
// holds the next one at its final step.
module running_mean_variance_accumulator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_value[31:0], weight[47:32], other_count[79:48], other_mean[111:80],
    // other_sq_dev[174:112], other_total[238:175], other_min[270:239],
    // other_max[302:271], zero[303]
    input  logic [303:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // total_count[31:0], running_mean[63:32], sq_dev_sum[126:64],
    // value_sum[190:127], min_value[222:191], max_value[254:223], zero[255]
    output logic [255:0] m_tdata
);

    rmva_pkg::cmd_t    cmd;
    rmva_pkg::status_t status;

    logic [31:0] total_count;
    logic [31:0] running_mean;
    logic [62:0] sq_dev_sum;
    logic [63:0] value_sum;
    logic [31:0] min_value;
    logic [31:0] max_value;

    rmva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmva_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .func         (s_tuser),
        .sample_value (s_tdata[31:0]),
        .weight       (s_tdata[47:32]),
        .other_count  (s_tdata[79:48]),
        .other_mean   (s_tdata[111:80]),
        .other_sq_dev (s_tdata[174:112]),
        .other_total  (s_tdata[238:175]),
        .other_min    (s_tdata[270:239]),
        .other_max    (s_tdata[302:271]),
        .total_count  (total_count),
        .running_mean (running_mean),
        .sq_dev_sum   (sq_dev_sum),
        .value_sum    (value_sum),
        .min_value    (min_value),
        .max_value    (max_value)
    );

    assign m_tdata = {1'b0, max_value, min_value, value_sum, sq_dev_sum,
                      running_mean, total_count};

endmodule
